// ----- sv/direct_mapped_cache_tag_lookup_unit_macros.svh -----
// -----------------------------------------------------------------------------
// Direct-mapped cache tag lookup: assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// -----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_TAG_LOOKUP_UNIT_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TAG_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define DMC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dmc_pkg.sv -----
// -----------------------------------------------------------------------------
// Direct-mapped cache tag lookup: shared package
// Sizes, register indexes and the tag store entry and write request types.
// -----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // Store geometry and field widths.
  localparam int unsigned NumLines   = 1024;
  localparam int unsigned LineW      = $clog2(NumLines);
  localparam int unsigned AddrW      = 32;
  localparam int unsigned TagW       = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 4;

  // Clamp limits for the configured field widths.
  localparam logic [CfgDataW-1:0] OffsetBitsMax = 4'd12;
  localparam logic [CfgDataW-1:0] IndexBitsMax  = 4'd10;

  // Reset values of the configuration registers.
  localparam logic [CfgDataW-1:0] OffsetBitsRst = 4'd4;
  localparam logic [CfgDataW-1:0] IndexBitsRst  = 4'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgOffsetBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIndexBits  = 2'd1;

  typedef logic [LineW-1:0] line_idx_t;

  // One line of the tag store.
  typedef struct packed {
    logic            valid;
    logic [TagW-1:0] tag;
  } entry_t;

  // Write request into the tag store.
  typedef struct packed {
    logic      we;
    line_idx_t addr;
    entry_t    data;
  } wr_req_t;

endpackage

`default_nettype wire

// ----- sv/dmc_tag_ram.sv -----
// -----------------------------------------------------------------------------
// Direct-mapped cache tag lookup: tag store
// Single-port-write, single-port-read synchronous memory of valid bit and tag
// per line, with the read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module dmc_tag_ram (
  input  wire logic             clk_i,
  input  wire dmc_pkg::wr_req_t wr_i,
  input  wire logic             rd_en_i,
  input  wire dmc_pkg::line_idx_t rd_addr_i,
  output dmc_pkg::entry_t       rd_data_o
);
  import dmc_pkg::*;

  entry_t mem_q [NumLines];
  entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/direct_mapped_cache_tag_lookup_unit.sv -----
// A result loads into the output register in the lookup state after its request is
// accepted, once the output slot is free. A request is taken only in the idle state,
// after the last one has done its tag store read and the read-modify-write of its line.
// A waiting result holds in the output register; the next request is taken.
// Reset: configuration, counters and control reset at once; the tag store is
// then cleared one line a cycle, all 1024 lines, with input stalled meanwhile.
// -----------------------------------------------------------------------------
// Direct-mapped cache tag lookup unit
// Splits each address into offset, index and tag, looks the line up, counts
// hits and misses and refills the line on a miss.
// -----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_cache_tag_lookup_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Lookup requests
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [dmc_pkg::AddrW-1:0]       in_address_i,
  // Results
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 out_hit_o,
  output logic [dmc_pkg::CountW-1:0]           out_hit_total_o,
  output logic [dmc_pkg::CountW-1:0]           out_miss_total_o,
  // Configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dmc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [dmc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import dmc_pkg::*;

  `include "direct_mapped_cache_tag_lookup_unit_macros.svh"

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e                state_q, state_d;
  line_idx_t             clr_q, clr_d;
  line_idx_t             idx_q, idx_d;
  logic [TagW-1:0]       tag_q, tag_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_hit_q, out_hit_d;
  logic [CountW-1:0]     hit_cnt_q, hit_cnt_d;
  logic [CountW-1:0]     miss_cnt_q, miss_cnt_d;
  logic [CfgDataW-1:0]   offset_bits_q, offset_bits_d;
  logic [CfgDataW-1:0]   index_bits_q, index_bits_d;

  logic [CfgDataW-1:0]   ob, ib;
  logic [CfgDataW:0]     tag_shift;
  logic [AddrW-1:0]      addr_sh;
  logic [AddrW-1:0]      tag_sh;
  line_idx_t             idx_mask;
  line_idx_t             acc_idx;
  logic                  accept;
  logic                  slot_free;
  logic                  produce;
  logic                  lookup_hit;
  logic                  lookup_miss;
  wr_req_t               ram_wr;
  entry_t                ram_rd;

  // Configuration registers are always ready; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    offset_bits_d = offset_bits_q;
    index_bits_d  = index_bits_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOffsetBits: offset_bits_d = cfg_data_i;
        CfgIndexBits:  index_bits_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Address split with the field widths clamped to their limits.
  assign ob        = (offset_bits_q > OffsetBitsMax) ? OffsetBitsMax : offset_bits_q;
  assign ib        = (index_bits_q > IndexBitsMax) ? IndexBitsMax : index_bits_q;
  assign tag_shift = {1'b0, ob} + {1'b0, ib};
  assign addr_sh   = in_address_i >> ob;
  assign tag_sh    = in_address_i >> tag_shift;
  assign idx_mask  = ~({LineW{1'b1}} << ib);
  assign acc_idx   = addr_sh[LineW-1:0] & idx_mask;

  // Handshakes.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign produce    = (state_q == ST_LOOKUP) && slot_free;

  // Hit test on the line read when the request was accepted.
  assign lookup_hit  = ram_rd.valid && (ram_rd.tag == tag_q);
  assign lookup_miss = produce && !lookup_hit;

  // Tag store write: clearing pass after reset, refill on a miss.
  always_comb begin
    ram_wr = '0;
    if (state_q == ST_CLEAR) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = clr_q;
    end else if (produce && !lookup_hit) begin
      ram_wr.we         = 1'b1;
      ram_wr.addr       = idx_q;
      ram_wr.data.valid = 1'b1;
      ram_wr.data.tag   = tag_q;
    end
  end

  dmc_tag_ram u_tag_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_en_i   (accept),
    .rd_addr_i (acc_idx),
    .rd_data_o (ram_rd)
  );

  // Sequencer and result register next values.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hit_d   = out_hit_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + line_idx_t'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_d   = acc_idx;
          tag_d   = tag_sh[TagW-1:0];
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (produce) begin
          out_valid_d = 1'b1;
          out_hit_d   = lookup_hit;
          if (lookup_hit) begin
            hit_cnt_d = (&hit_cnt_q) ? hit_cnt_q : hit_cnt_q + CountW'(1);
          end else begin
            miss_cnt_d = (&miss_cnt_q) ? miss_cnt_q : miss_cnt_q + CountW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // State, configuration and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      idx_q         <= '0;
      tag_q         <= '0;
      out_valid_q   <= 1'b0;
      out_hit_q     <= 1'b0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      offset_bits_q <= OffsetBitsRst;
      index_bits_q  <= IndexBitsRst;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      idx_q         <= idx_d;
      tag_q         <= tag_d;
      out_valid_q   <= out_valid_d;
      out_hit_q     <= out_hit_d;
      hit_cnt_q     <= hit_cnt_d;
      miss_cnt_q    <= miss_cnt_d;
      offset_bits_q <= offset_bits_d;
      index_bits_q  <= index_bits_d;
    end
  end

  // The result totals are the live counters, which move only as a result loads.
  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_hit_total_o  = hit_cnt_q;
  assign out_miss_total_o = miss_cnt_q;

  // Checks on the lookup and refill logic.
  `DMC_ASSERT_IMPL(a_clear_blocks_input, state_q == ST_CLEAR, in_stall_o, "taken in clear")
  `DMC_ASSERT_IMPL(a_miss_refills, lookup_miss, ram_wr.we && ram_wr.addr == idx_q, "no refill")
  `DMC_ASSERT_NEXT(a_hit_keeps_misses, produce && lookup_hit, $stable(miss_cnt_q), "misses moved")
  `DMC_ASSERT_NEXT(a_miss_keeps_hits, lookup_miss, $stable(hit_cnt_q), "hits moved")

endmodule

`default_nettype wire

// ----- bench/direct_mapped_cache_tag_lookup_unit_tb.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Direct-mapped cache tag lookup unit: self-checking testbench
// Drives lookup requests through the request channel, mirrors the tag store,
// the field split and the saturating counters in a local predictor, and
// compares every result field with the oldest predicted result. Several field
// width settings and idling patterns are run, including one long output hold.
// -----------------------------------------------------------------------------

module direct_mapped_cache_tag_lookup_unit_tb;

  import dmc_pkg::*;

  // Register numbers that the block decodes to nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int unsigned WatchdogLimit = 6000;
  localparam int unsigned HoldAfter     = 500;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RecentDepth   = 24;

  // One predicted or observed lookup result.
  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] hit_total;
    logic [CountW-1:0] miss_total;
  } lookup_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [AddrW-1:0]    in_address_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic                out_hit_o;
  logic [CountW-1:0]   out_hit_total_o;
  logic [CountW-1:0]   out_miss_total_o;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;

  // Local copy of the block's configuration and state.
  logic [CfgDataW-1:0] offset_w = OffsetBitsRst;
  logic [CfgDataW-1:0] index_w  = IndexBitsRst;
  logic                mirror_valid [NumLines];
  logic [TagW-1:0]     mirror_tag   [NumLines];
  logic [CountW-1:0]   hit_count  = '0;
  logic [CountW-1:0]   miss_count = '0;

  logic [AddrW-1:0]    address_queue [$];
  logic [AddrW-1:0]    recent_addresses [$];
  lookup_result_t      expected_lookups [$];

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  direct_mapped_cache_tag_lookup_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_address_i     (in_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_hit_o        (out_hit_o),
    .out_hit_total_o  (out_hit_total_o),
    .out_miss_total_o (out_miss_total_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Free-running clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Splits an address under the current widths, looks the line up in the
  // mirror, refills it on a miss and returns the result with both counts.
  function automatic lookup_result_t lookup_address(input logic [AddrW-1:0] addr);
    int unsigned    ob;
    int unsigned    ib;
    logic [AddrW-1:0] field;
    line_idx_t      line;
    logic [TagW-1:0] tag;
    lookup_result_t res;
    ob = (offset_w > OffsetBitsMax) ? OffsetBitsMax : offset_w;
    ib = (index_w > IndexBitsMax) ? IndexBitsMax : index_w;
    field = (addr >> ob) & ((32'd1 << ib) - 32'd1);
    line = line_idx_t'(field % NumLines);
    tag = addr >> (ob + ib);
    res.hit = mirror_valid[line] && (mirror_tag[line] == tag);
    if (res.hit) begin
      if (hit_count != {CountW{1'b1}}) hit_count = hit_count + 1'b1;
    end else begin
      if (miss_count != {CountW{1'b1}}) miss_count = miss_count + 1'b1;
      mirror_valid[line] = 1'b1;
      mirror_tag[line] = tag;
    end
    res.hit_total = hit_count;
    res.miss_total = miss_count;
    return res;
  endfunction

  // Random address, mostly revisiting recent blocks so that hits and
  // conflict misses both occur, with some fresh addresses and the extremes.
  function automatic logic [AddrW-1:0] random_address();
    int unsigned     ob;
    int unsigned     ib;
    int unsigned     pick;
    logic [AddrW-1:0] addr;
    ob = (offset_w > OffsetBitsMax) ? OffsetBitsMax : offset_w;
    ib = (index_w > IndexBitsMax) ? IndexBitsMax : index_w;
    pick = $urandom_range(0, 99);
    if (recent_addresses.size() == 0 || pick < 25) begin
      addr = $urandom();
    end else begin
      if (pick % 2 == 1)
        addr = recent_addresses[recent_addresses.size() - 1];
      else
        addr = recent_addresses[$urandom_range(0, recent_addresses.size() - 1)];
      if (pick < 70)
        addr = addr ^ ($urandom() & ((32'd1 << ob) - 32'd1));
      else if (pick < 85)
        addr = addr ^ ($urandom() << (ob + ib));
    end
    if (pick >= 97) addr = (pick == 97) ? '0 : '1;
    recent_addresses.push_back(addr);
    if (recent_addresses.size() > RecentDepth) void'(recent_addresses.pop_front());
    return addr;
  endfunction

  task automatic queue_address(input logic [AddrW-1:0] addr);
    address_queue.push_back(addr);
    items_queued++;
  endtask

  task automatic queue_random(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) queue_address(random_address());
  endtask

  // Waits until every request has been taken and every result checked.
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_lookups.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; drops valid again before returning.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgOffsetBits) offset_w = val;
    else if (idx == CfgIndexBits) index_w = val;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [CfgDataW-1:0] ob, input logic [CfgDataW-1:0] ib,
                             input int unsigned send_pct, input int unsigned recv_pct);
    wait_idle();
    write_reg(CfgOffsetBits, ob);
    write_reg(CfgIndexBits, ib);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Request driver: records and predicts each accepted request, then offers
  // the next pending address unless the current one is still stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_address_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_lookups.push_back(lookup_address(in_address_i));
        items_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (address_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          in_address_i <= address_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest
  // prediction and drives the output stall, with one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (expected_lookups.size() == 0) begin
          $error("result with no outstanding request: hit %0b, hits %0d, misses %0d",
                 out_hit_o, out_hit_total_o, out_miss_total_o);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_hit_o !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, out_hit_o);
            mismatches++;
          end
          if (out_hit_total_o !== want.hit_total) begin
            $error("hit_total: expected %0d, actual %0d", want.hit_total, out_hit_total_o);
            mismatches++;
          end
          if (out_miss_total_o !== want.miss_total) begin
            $error("miss_total: expected %0d, actual %0d", want.miss_total, out_miss_total_o);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && results_checked == HoldAfter) begin
        out_stall_i <= 1'b1;
        hold_left   <= HoldCycles;
        hold_done   <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                   (cfg_valid_i && cfg_ready_o)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < NumLines; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_tag[i]   = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset widths: repeats, same block, conflict eviction, top line.
    queue_address(32'h0000_0000);
    queue_address(32'h0000_0000);
    queue_address(32'h0000_000F);
    queue_address(32'hFFFF_FFFF);
    queue_address(32'hFFFF_FFF0);
    queue_address(32'h0000_4000);
    queue_address(32'h0000_0000);
    queue_address(32'h0000_3FF0);
    queue_address(32'h0000_3FFF);
    queue_address(32'hAAAA_AAAA);
    queue_address(32'h5555_5555);
    queue_address(32'h8000_0000);
    queue_address(32'h7FFF_FFFF);
    queue_address(32'hAAAA_AAAA);
    queue_random(200);

    // Both widths zero: a single line tagged with the whole address.
    reconfigure(4'd0, 4'd0, 48, 0);
    write_reg(CfgSpareA, 4'($urandom()));
    write_reg(CfgSpareB, 4'($urandom()));
    queue_address(32'h1234_5678);
    queue_address(32'h1234_5678);
    queue_address(32'h1234_5679);
    queue_address(32'hFFFF_FFFF);
    queue_address(32'hFFFF_FFFF);
    queue_address(32'h0000_0000);
    queue_random(210);

    // Oversized widths act as the largest ones; the long hold falls here.
    reconfigure(4'd15, 4'd15, 0, 48);
    queue_address(32'hFFFF_FFFF);
    queue_address(32'hFFFF_F000);
    queue_address(32'h003F_F000);
    queue_address(32'hFFC0_0000);
    queue_random(210);

    reconfigure(OffsetBitsMax, IndexBitsMax, 35, 35);
    queue_random(210);
    reconfigure(4'd2, 4'd3, 0, 0);
    queue_random(210);
    reconfigure(4'd7, 4'd6, 48, 0);
    queue_random(210);
    reconfigure(4'd0, 4'd10, 0, 48);
    queue_random(210);
    reconfigure(4'd12, 4'd0, 35, 35);
    queue_random(210);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_lookups.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
